// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the RTL of the ranking table.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/trt_pkg.sv =====
// ----------------------------------------------------------------------------
// trt_pkg
// Sizes, codes and cell control word of the transpose ranking table.
// ----------------------------------------------------------------------------
package trt_pkg;

    localparam int DEPTH       = 16;
    localparam int KEY_WIDTH   = 32;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int CMD_W       = 3;
    localparam int IDX_W       = 5;
    localparam int ST_W        = 3;

    typedef logic [KEY_WIDTH-1:0] t_key;
    typedef logic [CMD_W-1:0]     t_cmd;
    typedef logic [ST_W-1:0]      t_status;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [CNT_W-1:0]     t_cnt;

    localparam t_cmd CMD_ADD  = 3'd0;
    localparam t_cmd CMD_GET  = 3'd1;
    localparam t_cmd CMD_POS  = 3'd2;
    localparam t_cmd CMD_DOWN = 3'd3;
    localparam t_cmd CMD_TOP  = 3'd4;

    localparam t_status ST_ADDED   = 3'd0;
    localparam t_status ST_PRESENT = 3'd1;
    localparam t_status ST_MISS    = 3'd2;
    localparam t_status ST_FULL    = 3'd3;
    localparam t_status ST_EMPTY   = 3'd4;

    typedef struct packed {
        logic append;
        logic take_below;
        logic take_above;
        logic load_sh;
        logic shift_sh;
    } t_cell_ctl;

endpackage

// ===== sv/trt_cell.sv =====
// ----------------------------------------------------------------------------
// trt_cell
// One rank slot: key register, key compare, neighbour swap and a stage of
// the read-out shift line.
// ----------------------------------------------------------------------------
module trt_cell (
    input  logic             i_clk,
    input  trt_pkg::t_cell_ctl i_ctl,
    input  trt_pkg::t_key    i_new_key,
    input  trt_pkg::t_key    i_key_above,
    input  trt_pkg::t_key    i_key_below,
    input  trt_pkg::t_key    i_cmp_key,
    input  logic             i_occupied,
    input  trt_pkg::t_key    i_sh_below,
    output trt_pkg::t_key    o_key,
    output logic             o_match,
    output trt_pkg::t_key    o_sh
);
    import trt_pkg::*;

    t_key r_key;
    t_key r_sh;

    always_ff @(posedge i_clk) begin
        if (i_ctl.append) begin
            r_key <= i_new_key;
        end else if (i_ctl.take_below) begin
            r_key <= i_key_below;
        end else if (i_ctl.take_above) begin
            r_key <= i_key_above;
        end
        if (i_ctl.load_sh) begin
            r_sh <= r_key;
        end else if (i_ctl.shift_sh) begin
            r_sh <= i_sh_below;
        end
    end

    assign o_key   = r_key;
    assign o_match = i_occupied && (r_key == i_cmp_key);
    assign o_sh    = r_sh;

endmodule

// ===== sv/transpose_ranking_table.sv =====
// Handshake: a single-result word is registered out of S_EXEC once the output
// register is free; no input is taken before then. A top list of k keys holds
// the input off, one key per cycle off the read-out shift line unless stalled.
// Reset: synchronous, active low; clears the entry count and handshake state,
// no clearing pass is run.
// ----------------------------------------------------------------------------
// transpose_ranking_table
// Self-organising key table with transpose promotion, built as a chain of
// rank cells with parallel compare and neighbour swap.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module transpose_ranking_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  trt_pkg::t_cmd     i_cmd,
    input  trt_pkg::t_key     i_key,
    input  trt_pkg::t_idx     i_index,
    output logic              o_valid,
    input  logic              i_ready,
    output trt_pkg::t_key     o_key_out,
    output trt_pkg::t_idx     o_rank_out,
    output trt_pkg::t_status  o_status,
    output logic              o_last
);
    import trt_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_TOP} t_state;

    t_state  r_state, n_state;
    t_cmd    r_cmd;
    t_key    r_key;
    t_idx    r_idx;
    t_cnt    r_cnt, n_cnt;
    t_cnt    r_top_k, n_top_k;
    t_cnt    r_top_i, n_top_i;
    logic    r_o_valid, n_o_valid;
    t_key    r_o_key, n_o_key;
    t_idx    r_o_rank, n_o_rank;
    t_status r_o_status, n_o_status;
    logic    r_o_last, n_o_last;

    t_key      w_key   [DEPTH];
    t_key      w_sh    [DEPTH];
    t_key      w_above [DEPTH];
    t_key      w_below [DEPTH];
    t_key      w_sh_in [DEPTH];
    logic      [DEPTH-1:0] w_match;
    t_cell_ctl w_ctl   [DEPTH];

    logic  w_hit;
    t_slot w_hit_pos;
    t_slot w_rd_slot;
    t_key  w_rd_key;
    logic  w_out_free;
    t_cnt  w_top_k;
    logic  w_append, w_swap, w_load_sh, w_shift_sh;
    t_slot w_swap_p;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            trt_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl[gi]),
                .i_new_key   (r_key),
                .i_key_above (w_above[gi]),
                .i_key_below (w_below[gi]),
                .i_cmp_key   (r_key),
                .i_occupied  (CNT_W'(gi) < r_cnt),
                .i_sh_below  (w_sh_in[gi]),
                .o_key       (w_key[gi]),
                .o_match     (w_match[gi]),
                .o_sh        (w_sh[gi])
            );
        end
    endgenerate

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_above[i] = (i == 0) ? w_key[0] : w_key[(i == 0) ? 0 : i - 1];
            w_below[i] = (i == DEPTH - 1) ? w_key[i] : w_key[(i == DEPTH - 1) ? i : i + 1];
            w_sh_in[i] = (i == DEPTH - 1) ? '0 : w_sh[(i == DEPTH - 1) ? i : i + 1];
            w_ctl[i].append     = w_append && (r_cnt == CNT_W'(i));
            w_ctl[i].take_below = w_swap && (CNT_W'(w_swap_p) == CNT_W'(i + 1));
            w_ctl[i].take_above = w_swap && (w_swap_p == SLOT_W'(i));
            w_ctl[i].load_sh    = w_load_sh;
            w_ctl[i].shift_sh   = w_shift_sh;
        end
    end

    always_comb begin
        w_hit_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_match[i]) begin
                w_hit_pos = SLOT_W'(i);
            end
        end
    end

    assign w_hit      = |w_match;
    assign w_rd_slot  = SLOT_W'(r_idx - 1'b1);
    assign w_rd_key   = w_key[w_rd_slot];
    assign w_out_free = !r_o_valid || i_ready;
    assign w_top_k    = (r_idx > IDX_W'(r_cnt)) ? r_cnt : CNT_W'(r_idx);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_top_k    = r_top_k;
        n_top_i    = r_top_i;
        n_o_valid  = r_o_valid && !i_ready;
        n_o_key    = r_o_key;
        n_o_rank   = r_o_rank;
        n_o_status = r_o_status;
        n_o_last   = r_o_last;
        w_append   = 1'b0;
        w_swap     = 1'b0;
        w_swap_p   = '0;
        w_load_sh  = 1'b0;
        w_shift_sh = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state    = S_IDLE;
                    n_o_valid  = 1'b1;
                    n_o_last   = 1'b1;
                    n_o_key    = '0;
                    n_o_rank   = '0;
                    n_o_status = ST_MISS;
                    if (r_cmd == CMD_ADD) begin
                        n_o_key = r_key;
                        if (w_hit) begin
                            n_o_rank   = IDX_W'(w_hit_pos) + 1'b1;
                            n_o_status = ST_PRESENT;
                        end else if (r_cnt == CNT_W'(DEPTH)) begin
                            n_o_status = ST_FULL;
                        end else begin
                            w_append   = 1'b1;
                            n_cnt      = r_cnt + 1'b1;
                            n_o_rank   = IDX_W'(r_cnt) + 1'b1;
                            n_o_status = ST_ADDED;
                        end
                    end else if (r_cmd > CMD_TOP) begin
                        n_o_status = ST_MISS;
                    end else if (r_cnt == '0) begin
                        n_o_status = ST_EMPTY;
                    end else begin
                        case (r_cmd)
                            CMD_GET: begin
                                if (r_idx != '0 && r_idx <= IDX_W'(r_cnt)) begin
                                    n_o_key    = w_rd_key;
                                    n_o_rank   = r_idx;
                                    n_o_status = ST_PRESENT;
                                    w_swap_p   = w_rd_slot;
                                    w_swap     = (w_rd_slot != '0);
                                end
                            end
                            CMD_POS: begin
                                if (w_hit) begin
                                    n_o_key    = r_key;
                                    n_o_rank   = IDX_W'(w_hit_pos) + 1'b1;
                                    n_o_status = ST_PRESENT;
                                    w_swap_p   = w_hit_pos;
                                    w_swap     = (w_hit_pos != '0);
                                end
                            end
                            CMD_DOWN: begin
                                if (r_idx != '0 && r_idx < IDX_W'(r_cnt)) begin
                                    n_o_key    = w_rd_key;
                                    n_o_rank   = r_idx;
                                    n_o_status = ST_PRESENT;
                                    w_swap_p   = SLOT_W'(r_idx);
                                    w_swap     = 1'b1;
                                end
                            end
                            CMD_TOP: begin
                                if (w_top_k != '0) begin
                                    n_o_valid = r_o_valid && !i_ready;
                                    n_o_key   = r_o_key;
                                    n_o_rank  = r_o_rank;
                                    n_o_status = r_o_status;
                                    n_o_last  = r_o_last;
                                    w_load_sh = 1'b1;
                                    n_top_k   = w_top_k;
                                    n_top_i   = '0;
                                    n_state   = S_TOP;
                                end
                            end
                            default: begin
                                n_o_status = ST_MISS;
                            end
                        endcase
                    end
                end
            end
            S_TOP: begin
                if (w_out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_key    = w_sh[0];
                    n_o_rank   = IDX_W'(r_top_i) + 1'b1;
                    n_o_status = ST_PRESENT;
                    n_o_last   = (r_top_i + 1'b1 == r_top_k);
                    w_shift_sh = 1'b1;
                    n_top_i    = r_top_i + 1'b1;
                    if (r_top_i + 1'b1 == r_top_k) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_top_k   <= '0;
            r_top_i   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_top_k   <= n_top_k;
            r_top_i   <= n_top_i;
            r_o_valid <= n_o_valid;
        end
        if (i_valid && o_ready) begin
            r_cmd <= i_cmd;
            r_key <= i_key;
            r_idx <= i_index;
        end
        r_o_key    <= n_o_key;
        r_o_rank   <= n_o_rank;
        r_o_status <= n_o_status;
        r_o_last   <= n_o_last;
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_o_valid;
    assign o_key_out  = r_o_key;
    assign o_rank_out = r_o_rank;
    assign o_status   = r_o_status;
    assign o_last     = r_o_last;

    `ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_W'(DEPTH), "entry count above depth")
    `ASSERT_ALWAYS(a_cnt_step, i_clk, i_rst_n, (r_cnt == $past(r_cnt)) || (r_cnt == $past(r_cnt) + 1'b1), "entry count moved by other than one")
    `ASSERT_ALWAYS(a_key_unique, i_clk, i_rst_n, $onehot0(w_match), "key held in more than one rank")
    `ASSERT_IMPL(a_rank_set, i_clk, i_rst_n, o_valid && (o_status == ST_ADDED || o_status == ST_PRESENT), o_rank_out != '0, "hit reported without a rank")

endmodule
